// File: hdl/typed_spill_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// Typed spill slot allocator assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TYPED_SPILL_SLOT_ALLOCATOR_MACROS_SVH
`define TYPED_SPILL_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define TSSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tssa_pkg.sv
// ----------------------------------------------------------------------------
// Typed spill slot allocator package
// Types, sizes and codes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package tssa_pkg;

  localparam int SLOTS      = 256;
  localparam int SLOT_BYTES = 8;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int OFS_W  = 20;
  localparam int BASE_W = 19;
  localparam int TYPE_W = 8;
  localparam int REG_W  = 3;
  localparam int STS_W  = 2;
  localparam int BKT_N  = 4;
  localparam int BKT_W  = 2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STS_W-1:0] ST_BAD_POS = 2'd2;

  localparam logic [REG_W-1:0] REG_SPILL_BASE = 3'd0;
  localparam logic [REG_W-1:0] REG_CODE_NUM32 = 3'd1;
  localparam logic [REG_W-1:0] REG_CODE_NUM64 = 3'd2;
  localparam logic [REG_W-1:0] REG_CODE_STR   = 3'd3;
  localparam logic [REG_W-1:0] REG_CODE_OBJ   = 3'd4;

  localparam logic [BKT_W-1:0] BKT_OTHER = 2'd0;
  localparam logic [BKT_W-1:0] BKT_FLOAT = 2'd1;
  localparam logic [BKT_W-1:0] BKT_STR   = 2'd2;
  localparam logic [BKT_W-1:0] BKT_OBJ   = 2'd3;

  localparam logic [BASE_W-1:0]        RST_SPILL_BASE = '0;
  localparam logic signed [TYPE_W-1:0] RST_CODE_NUM32 = 8'sd5;
  localparam logic signed [TYPE_W-1:0] RST_CODE_NUM64 = 8'sd6;
  localparam logic signed [TYPE_W-1:0] RST_CODE_STR   = 8'sd7;
  localparam logic signed [TYPE_W-1:0] RST_CODE_OBJ   = 8'sd8;

  typedef struct packed {
    logic                     opcode;
    logic signed [TYPE_W-1:0] value_type;
    logic [OFS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [IDX_W-1:0] slot_index;
    logic [CNT_W-1:0] slots_in_use;
    logic [STS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic head_hit;
  } sts_t;

endpackage

// File: hdl/tssa_ctrl.sv
// ----------------------------------------------------------------------------
// Typed spill slot allocator controller
// Sequences one item through execute and optional link read, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module tssa_ctrl
  import tssa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.head_hit) begin
          state_next = S_LINK;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LINK: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/tssa_dpath.sv
// ----------------------------------------------------------------------------
// Typed spill slot allocator datapath
// Configuration registers, bucket heads, slot counter, link memory and the
// result register.
// ----------------------------------------------------------------------------
module tssa_dpath
  import tssa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [REG_W-1:0]  wr_index,
  input  logic [BASE_W-1:0] wr_data,
  input  req_t              req,
  output rsp_t              rsp,
  input  cmd_t              cmd,
  output sts_t              sts
);

  logic [BASE_W-1:0]        spill_base;
  logic signed [TYPE_W-1:0] code_num32;
  logic signed [TYPE_W-1:0] code_num64;
  logic signed [TYPE_W-1:0] code_str;
  logic signed [TYPE_W-1:0] code_obj;

  logic [IDX_W-1:0] head_idx [BKT_N];
  logic             head_vld [BKT_N];
  logic [CNT_W-1:0] slot_count;
  logic [CNT_W-1:0] slot_count_next;

  link_t link_mem [SLOTS];
  link_t link_rd;

  req_t item;
  rsp_t rsp_next;

  logic [BKT_W-1:0] bkt;
  logic [IDX_W-1:0] hd_idx;
  logic             hd_vld;
  logic [OFS_W-1:0] base_ext;
  logic [OFS_W-1:0] diff;
  logic [OFS_W-1:0] quot;
  logic             rel_ok;
  logic [IDX_W-1:0] rel_idx;
  logic             fresh;
  logic [IDX_W-1:0] sel_idx;
  logic [OFS_W-1:0] sel_ofs;

  always_comb begin
    if (item.value_type == code_num32 || item.value_type == code_num64) begin
      bkt = BKT_FLOAT;
    end else if (item.value_type == code_str) begin
      bkt = BKT_STR;
    end else if (item.value_type == code_obj) begin
      bkt = BKT_OBJ;
    end else begin
      bkt = BKT_OTHER;
    end
  end

  assign hd_idx   = head_idx[bkt];
  assign hd_vld   = head_vld[bkt];
  assign base_ext = OFS_W'(spill_base);
  assign diff     = item.position - base_ext;
  assign quot     = OFS_W'(diff / SLOT_BYTES);
  assign rel_ok   = (item.position >= base_ext) && ((diff % SLOT_BYTES) == '0)
                    && (quot < OFS_W'(slot_count));
  assign rel_idx  = quot[IDX_W-1:0];
  assign fresh    = slot_count < CNT_W'(SLOTS);
  assign sel_idx  = hd_vld ? hd_idx : slot_count[IDX_W-1:0];
  assign sel_ofs  = base_ext + OFS_W'(OFS_W'(sel_idx) * SLOT_BYTES);

  assign sts.head_hit = (item.opcode == OP_ALLOC) && hd_vld;

  always_comb begin
    slot_count_next       = slot_count;
    rsp_next.offset       = '0;
    rsp_next.slot_index   = '0;
    rsp_next.status       = ST_OK;
    case (item.opcode)
      OP_ALLOC: begin
        if (hd_vld || fresh) begin
          rsp_next.offset     = sel_ofs;
          rsp_next.slot_index = sel_idx;
          if (!hd_vld) begin
            slot_count_next = slot_count + CNT_W'(1);
          end
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      default: begin
        rsp_next.offset = item.position;
        if (rel_ok) begin
          rsp_next.slot_index = rel_idx;
        end else begin
          rsp_next.status = ST_BAD_POS;
        end
      end
    endcase
    rsp_next.slots_in_use = slot_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spill_base <= RST_SPILL_BASE;
      code_num32 <= RST_CODE_NUM32;
      code_num64 <= RST_CODE_NUM64;
      code_str   <= RST_CODE_STR;
      code_obj   <= RST_CODE_OBJ;
      slot_count <= '0;
      for (int b = 0; b < BKT_N; b++) begin
        head_vld[b] <= 1'b0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_SPILL_BASE: spill_base <= wr_data;
          REG_CODE_NUM32: code_num32 <= wr_data[TYPE_W-1:0];
          REG_CODE_NUM64: code_num64 <= wr_data[TYPE_W-1:0];
          REG_CODE_STR:   code_str   <= wr_data[TYPE_W-1:0];
          REG_CODE_OBJ:   code_obj   <= wr_data[TYPE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        slot_count <= slot_count_next;
        if (item.opcode == OP_ALLOC) begin
          if (hd_vld) begin
            head_vld[bkt] <= link_rd.vld;
          end
        end else if (rel_ok) begin
          head_vld[bkt] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
      if (item.opcode == OP_ALLOC) begin
        if (hd_vld) begin
          head_idx[bkt] <= link_rd.idx;
        end
      end else if (rel_ok) begin
        head_idx[bkt] <= rel_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && item.opcode == OP_RELEASE && rel_ok) begin
      link_mem[rel_idx] <= '{vld: hd_vld, idx: hd_idx};
    end
    link_rd <= link_mem[hd_idx];
  end

endmodule

// File: hdl/typed_spill_slot_allocator.sv
// ----------------------------------------------------------------------------
// Typed spill slot allocator
// Hands out and takes back fixed-size spill slots from four typed free lists.
// ----------------------------------------------------------------------------
// One item at a time: a release or a fresh allocate passes through the
// execute state before the next acceptance, an allocate that reuses a free
// slot also through the link state, for the registered link memory read.
// The result register lets the next item be accepted while a result waits;
// an item only completes once that register is free. No clearing pass
// after reset.
module typed_spill_slot_allocator
  import tssa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [REG_W-1:0]  wr_index,
  input  logic [BASE_W-1:0] wr_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp
);

`include "typed_spill_slot_allocator_macros.svh"

  cmd_t cmd;
  sts_t sts;

  tssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tssa_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .sts      (sts)
  );

  `TSSA_ASSERT_NOW(a_commit_slot_free, clk, rst, cmd.commit, (!rsp_valid || rsp_ready), "item completed over a pending result")
  `TSSA_ASSERT_NEXT(a_one_in_flight, clk, rst, (req_valid && req_ready), !req_ready, "item accepted while another is in flight")
  `TSSA_ASSERT_NOW(a_full_count, clk, rst, (rsp_valid && rsp.status == ST_FULL), (rsp.slots_in_use == CNT_W'(SLOTS)), "table full reported below capacity")
  `TSSA_ASSERT_NOW(a_ok_index, clk, rst, (rsp_valid && rsp.status == ST_OK), (CNT_W'(rsp.slot_index) < rsp.slots_in_use), "slot index beyond created slots")

endmodule
